// File: design/lfid_pkg.sv
// Shared constants, codes and controller/datapath interface types for the id allocator.
package lfid_pkg;

	localparam int ID_W         = 9;
	localparam int MODE_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int DATA_W       = 16;
	localparam int WORD_W       = 32;
	localparam int BIT_W        = 5;
	localparam int ID_COUNT_DEF = 256;

	localparam logic [ID_W-1:0] HIGHEST_ID_RST = 9'd256;

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLAIM   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic load;
		logic scan;
		logic put;
	} dp_cmd_t;

	typedef struct packed {
		logic needs_mem;
		logic done;
		logic out_free;
	} dp_stat_t;

endpackage

// File: design/lowest_free_id_allocator.sv
// Top level of the lowest-free identifier allocator.
//
// Requests arrive on the s_ stream, one beat per request: allocate the lowest
// free identifier, claim a given one, or release a given one. Each request
// gives exactly one response beat on the m_ stream with a status and an id.
// highest_id sets the largest usable identifier; write it only while idle.
//
// One request is in flight at a time. Claim and release read the bitmap word
// at the accept, then write it back and pass the response to the output stage.
// Allocate scans the used bitmap one 32-bit word per cycle through a single
// find-first-zero unit, stopping at a free bit or at the word that holds the
// limit, then passes the response on. Rejected requests and allocates under
// a zero limit skip the bitmap and go straight to the output stage.
// s_tready rises at the edge that loads the response register, so the next
// request may be accepted while that response waits on a stalled receiver;
// that request then waits for the output and s_tready stays low meanwhile.
// Reset marks every identifier free at once (one valid flag per bitmap word)
// and sets highest_id to 256; no clearing pass is needed.
module lowest_free_id_allocator #(
	parameter int ID_COUNT = lfid_pkg::ID_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        highest_id_we,
	input  logic [lfid_pkg::ID_W-1:0]   highest_id,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lfid_pkg::DATA_W-1:0] s_tdata,  // mode[1:0], id[10:2], zero fill
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lfid_pkg::DATA_W-1:0] m_tdata   // status[1:0], granted_id[10:2], zero fill
);
	import lfid_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lfid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfid_dp #(
		.ID_COUNT (ID_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.highest_id_we (highest_id_we),
		.highest_id    (highest_id),
		.s_tdata       (s_tdata),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

// File: design/lfid_ctrl.sv
// Controller state machine: accept, scan the bitmap words, hand the result to the output stage.
module lfid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lfid_pkg::dp_stat_t stat,
	output lfid_pkg::dp_cmd_t  cmd
);
	import lfid_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_PUT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.scan = 1'b0;
		cmd.put  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = stat.needs_mem ? S_CHECK : S_PUT;
				end
			end
			S_CHECK: begin
				cmd.scan = 1'b1;
				if (stat.done) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (stat.out_free) begin
					cmd.put = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/lfid_dp.sv
// Datapath: limit register, bitmap word memory, find-first-zero and the output register.
module lfid_dp #(
	parameter int ID_COUNT = lfid_pkg::ID_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        highest_id_we,
	input  logic [lfid_pkg::ID_W-1:0]   highest_id,
	input  logic [lfid_pkg::DATA_W-1:0] s_tdata,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [lfid_pkg::DATA_W-1:0] m_tdata,
	input  lfid_pkg::dp_cmd_t           cmd,
	output lfid_pkg::dp_stat_t          stat
);
	import lfid_pkg::*;

	localparam int WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CAP   = (ID_COUNT > (2**ID_W - 1)) ? (2**ID_W - 1) : ID_COUNT;
	localparam int PAD_W = DATA_W - STATUS_W - ID_W;

	// limit and word memory
	logic [ID_W-1:0]   hid_q;
	logic [WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]  wv_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              rd_valid_q;

	// item context
	logic              alloc_q;
	logic              clear_q;
	logic [ID_W-1:0]   id_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WAW-1:0]    word_q;
	logic [ID_W-1:0]   lim_q;

	logic [STATUS_W-1:0] pend_status_q;
	logic [ID_W-1:0]     pend_id_q;
	logic                m_tvalid_q;
	logic [DATA_W-1:0]   m_tdata_q;

	logic [MODE_W-1:0] in_mode;
	logic [ID_W-1:0]   in_id;
	logic [ID_W-1:0]   in_idm1;
	logic [ID_W-1:0]   lim;
	logic              in_alloc;
	logic              in_cr;
	logic              in_id_ok;
	logic [WAW-1:0]    word_d;
	logic [WAW-1:0]    rd_addr;

	logic [WORD_W-1:0] cur;
	logic [ID_W-1:0]   limm1;
	logic              is_last;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] free;
	logic [WORD_W-1:0] low;
	logic [BIT_W-1:0]  idx;
	logic              found;
	logic [WORD_W-1:0] bitsel;
	logic [WORD_W-1:0] new_word;
	logic              scan_done;
	logic              commit;
	logic              advance;
	logic [ID_W-1:0]   gid;

	assign in_mode  = s_tdata[MODE_W-1:0];
	assign in_id    = s_tdata[MODE_W+ID_W-1:MODE_W];
	assign in_idm1  = in_id - ID_W'(1);
	assign lim      = (hid_q > ID_W'(CAP)) ? ID_W'(CAP) : hid_q;
	assign in_alloc = (in_mode == MODE_ALLOC);
	assign in_cr    = (in_mode == MODE_CLAIM) || (in_mode == MODE_RELEASE);
	assign in_id_ok = (in_id != '0) && (in_id <= lim);
	assign word_d   = (in_cr && in_id_ok) ? WAW'(in_idm1 >> BIT_W) : '0;

	assign stat.needs_mem = (in_alloc && (lim != '0)) || (in_cr && in_id_ok);

	// words never written read as all free
	assign cur     = rd_valid_q ? rd_word_q : '0;
	assign limm1   = lim_q - ID_W'(1);
	assign is_last = (ID_W'(word_q) == (limm1 >> BIT_W));
	assign mask    = is_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - limm1[BIT_W-1:0]))
	                         : {WORD_W{1'b1}};
	assign free    = ~cur & mask;
	assign found   = |free;
	assign low     = free & (~free + WORD_W'(1));

	always_comb begin
		idx = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (low[b]) begin
				idx = idx | BIT_W'(b);
			end
		end
	end

	assign bitsel    = WORD_W'(1) << bit_q;
	assign new_word  = alloc_q ? (cur | low) : (clear_q ? (cur & ~bitsel) : (cur | bitsel));
	assign scan_done = !alloc_q || found || is_last;
	assign commit    = cmd.scan && (!alloc_q || found);
	assign advance   = cmd.scan && !scan_done;
	assign gid       = ID_W'({word_q, idx}) + ID_W'(1);

	assign stat.done     = scan_done;
	assign stat.out_free = !m_tvalid_q || m_tready;

	// read one word ahead while scanning
	assign rd_addr = cmd.load ? word_d : (advance ? word_q + WAW'(1) : word_q);

	always_ff @(posedge clk) begin
		if (commit) begin
			mem[word_q] <= new_word;
		end
		rd_word_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q       <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				wv_q[word_q] <= 1'b1;
			end
			rd_valid_q <= wv_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hid_q <= HIGHEST_ID_RST;
		end else if (highest_id_we) begin
			hid_q <= highest_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			alloc_q       <= in_alloc;
			clear_q       <= (in_mode == MODE_RELEASE);
			id_q          <= in_id;
			bit_q         <= in_idm1[BIT_W-1:0];
			word_q        <= word_d;
			lim_q         <= lim;
			pend_status_q <= in_alloc ? ST_FULL : ST_REJECT;
			pend_id_q     <= '0;
		end else begin
			if (advance) begin
				word_q <= word_q + WAW'(1);
			end
			if (cmd.scan && scan_done) begin
				pend_status_q <= (!alloc_q || found) ? ST_DONE : ST_FULL;
				pend_id_q     <= alloc_q ? (found ? gid : '0) : id_q;
			end
		end
		if (cmd.put) begin
			m_tdata_q <= {{PAD_W{1'b0}}, pend_id_q, pend_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.put) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: design/lfid_chk.sv
// Port-level checker for the allocator, bound to the top level.
module lfid_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [lfid_pkg::DATA_W-1:0] m_tdata
);
	import lfid_pkg::*;

	logic [STATUS_W-1:0] r_status;
	logic [ID_W-1:0]     r_id;

	assign r_status = m_tdata[STATUS_W-1:0];
	assign r_id     = m_tdata[STATUS_W+ID_W-1:STATUS_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("response beat changed while stalled");

	// one request in flight: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_id_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((r_status == ST_DONE) == (r_id != '0)))
		else $error("granted id does not match status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (r_status == ST_DONE || r_status == ST_REJECT || r_status == ST_FULL))
		else $error("undefined status code");

endmodule

bind lowest_free_id_allocator lfid_chk u_chk (.*);
